// ----- rtl/core/mtep_pkg.sv -----
// Shared types, codes and helpers for the MIDI track event parser.
`timescale 1ns / 1ps

package mtep_pkg;

  localparam logic [7:0] STATUS_FLAG   = 8'h80;
  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] EOT_TYPE      = 8'h2F;
  localparam logic [7:0] LOW7_MASK     = 8'h7F;
  localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
  localparam logic [7:0] CHAN_PRESSURE = 8'hD0;
  localparam logic [7:0] PROG_CHANGE   = 8'hC0;
  localparam logic [7:0] LOW_STATUS    = 8'h40;
  localparam logic [7:0] NO_SECOND     = 8'd127;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_EVENT   = 2'd0,
    KIND_META    = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_MLEN   = 3'd5,
    PH_MDATA  = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  // One classified byte of the track body.
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       msb;       // status byte, or "more bytes follow" in a varlen
    logic       is_meta;   // byte is FF
    logic       is_eot;    // byte is the end-of-track meta type
  } mtep_beat_t;

  function automatic logic two_data(input logic [7:0] st);
    logic [7:0] hi;
    hi = st & NIBBLE_MASK;
    return (hi != CHAN_PRESSURE) && (hi != PROG_CHANGE) && (hi > LOW_STATUS);
  endfunction

endpackage

// ----- rtl/core/mtep_front.sv -----
// Front end: accept input beats, classify them and hold them in a short queue.
`timescale 1ns / 1ps

module mtep_front
  import mtep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_restart,
  output logic       q_valid,
  output mtep_beat_t q_beat,
  input  logic       q_pop
);

  mtep_beat_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       count_r, count_nxt;
  mtep_beat_t              beat;
  logic                    push;
  logic                    pop;

  always_comb begin
    beat.data    = in_data_byte;
    beat.restart = in_restart;
    beat.msb     = (in_data_byte & STATUS_FLAG) != 8'd0;
    beat.is_meta = in_data_byte == META_STATUS;
    beat.is_eot  = in_data_byte == EOT_TYPE;
  end

  assign in_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign q_valid  = count_r != '0;
  assign q_beat   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= beat;
    end
  end

endmodule

// ----- rtl/core/mtep_back.sv -----
// Back end: run the track parse state machine and hold the result register.
`timescale 1ns / 1ps

module mtep_back
  import mtep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  mtep_beat_t  q_beat,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_delta_time,
  output logic [7:0]  out_status,
  output logic [7:0]  out_first_data,
  output logic [7:0]  out_second_data,
  output logic [31:0] out_meta_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload,
  output logic        out_end_of_track
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  running_r, running_nxt;
  logic [31:0] delta_r, delta_nxt;
  logic [7:0]  cur_status_r, cur_status_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        first_eot_r, first_eot_nxt;
  logic [31:0] length_r, length_nxt;
  logic [31:0] left_r, left_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] o_delta_r, o_delta_nxt;
  logic [7:0]  o_status_r, o_status_nxt;
  logic [7:0]  o_first_r, o_first_nxt;
  logic [7:0]  o_second_r, o_second_nxt;
  logic [31:0] o_length_r, o_length_nxt;
  logic [7:0]  o_payload_r, o_payload_nxt;
  logic        o_last_r, o_last_nxt;
  logic        o_eot_r, o_eot_nxt;

  logic        take;
  logic        emit;
  logic        finish;
  logic [6:0]  low7;
  logic [31:0] left_dec;

  // Advance only when the result register is free or draining this cycle.
  assign take  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = take;
  assign low7  = q_beat.data[6:0];

  always_comb begin
    phase_nxt      = phase_r;
    running_nxt    = running_r;
    delta_nxt      = delta_r;
    cur_status_nxt = cur_status_r;
    first_nxt      = first_r;
    first_eot_nxt  = first_eot_r;
    length_nxt     = length_r;
    left_nxt       = left_r;
    emit           = 1'b0;
    finish         = 1'b0;
    kind_nxt       = KIND_EVENT;
    o_second_nxt   = NO_SECOND;
    o_payload_nxt  = 8'd0;
    o_last_nxt     = 1'b0;
    left_dec       = left_r - 32'd1;

    if (take) begin
      if (q_beat.restart) begin
        phase_nxt  = PH_DELTA;
        delta_nxt  = 32'd0;
        length_nxt = 32'd0;
        left_nxt   = 32'd0;
      end
      left_dec = left_nxt - 32'd1;

      unique case (phase_nxt)
        PH_DELTA: begin
          delta_nxt = {delta_nxt[24:0], low7};
          if (!q_beat.msb) begin
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (q_beat.msb) begin
            cur_status_nxt = q_beat.data;
            if (q_beat.is_meta) begin
              phase_nxt = PH_MTYPE;
            end else begin
              running_nxt = q_beat.data;
              phase_nxt   = PH_DATA1;
            end
          end else begin
            // Running status: this byte is already the first data byte.
            cur_status_nxt = running_r;
            first_nxt      = q_beat.data;
            first_eot_nxt  = q_beat.is_eot;
            if (two_data(running_r)) begin
              phase_nxt = PH_DATA2;
            end else begin
              emit   = 1'b1;
              finish = 1'b1;
            end
          end
        end
        PH_DATA1: begin
          first_nxt     = q_beat.data;
          first_eot_nxt = q_beat.is_eot;
          if (two_data(cur_status_r)) begin
            phase_nxt = PH_DATA2;
          end else begin
            emit   = 1'b1;
            finish = 1'b1;
          end
        end
        PH_DATA2: begin
          o_second_nxt = q_beat.data;
          emit         = 1'b1;
          finish       = 1'b1;
        end
        PH_MTYPE: begin
          first_nxt     = q_beat.data;
          first_eot_nxt = q_beat.is_eot;
          length_nxt    = 32'd0;
          phase_nxt     = PH_MLEN;
        end
        PH_MLEN: begin
          length_nxt = {length_nxt[24:0], low7};
          if (!q_beat.msb) begin
            emit         = 1'b1;
            kind_nxt     = KIND_META;
            o_second_nxt = 8'd0;
            left_nxt     = length_nxt;
            if (length_nxt == 32'd0) begin
              finish = 1'b1;
            end else begin
              phase_nxt = PH_MDATA;
            end
          end
        end
        PH_MDATA: begin
          left_nxt      = left_dec;
          emit          = 1'b1;
          kind_nxt      = KIND_PAYLOAD;
          o_second_nxt  = 8'd0;
          o_payload_nxt = q_beat.data;
          o_last_nxt    = left_dec == 32'd0;
          finish        = left_dec == 32'd0;
        end
        PH_DONE: begin
          // drop everything until a restart beat
        end
        default: begin
        end
      endcase
    end

    o_delta_nxt  = delta_nxt;
    o_status_nxt = cur_status_nxt;
    o_first_nxt  = first_nxt;
    o_length_nxt = (kind_nxt == KIND_EVENT) ? 32'd0 : length_nxt;
    o_eot_nxt    = (kind_nxt != KIND_EVENT) && (cur_status_nxt == META_STATUS) &&
                   first_eot_nxt;

    if (finish) begin
      delta_nxt = 32'd0;
      phase_nxt = ((cur_status_nxt == META_STATUS) && first_eot_nxt) ? PH_DONE
                                                                      : PH_DELTA;
    end

    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DELTA;
      running_r    <= 8'd0;
      delta_r      <= 32'd0;
      cur_status_r <= 8'd0;
      first_r      <= 8'd0;
      first_eot_r  <= 1'b0;
      length_r     <= 32'd0;
      left_r       <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      running_r    <= running_nxt;
      delta_r      <= delta_nxt;
      cur_status_r <= cur_status_nxt;
      first_r      <= first_nxt;
      first_eot_r  <= first_eot_nxt;
      length_r     <= length_nxt;
      left_r       <= left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind_r      <= kind_nxt;
      o_delta_r   <= o_delta_nxt;
      o_status_r  <= o_status_nxt;
      o_first_r   <= o_first_nxt;
      o_second_r  <= o_second_nxt;
      o_length_r  <= o_length_nxt;
      o_payload_r <= o_payload_nxt;
      o_last_r    <= o_last_nxt;
      o_eot_r     <= o_eot_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_delta_time   = o_delta_r;
  assign out_status       = o_status_r;
  assign out_first_data   = o_first_r;
  assign out_second_data  = o_second_r;
  assign out_meta_length  = o_length_r;
  assign out_payload_byte = o_payload_r;
  assign out_last_payload = o_last_r;
  assign out_end_of_track = o_eot_r;

endmodule

// ----- rtl/core/midi_track_event_parser.sv -----
// MIDI track event parser: receives track body bytes, delivers decoded events.
//
// Input channel (in_valid/in_ready): one track body byte per beat in
// in_data_byte; in_restart marks the first byte of a new track body.
// Running status survives a restart; everything else of the parse restarts.
// Output channel (out_valid/out_ready): one beat per channel or system
// event, per meta event header and per meta payload byte; out_kind tells
// them apart. Bytes that complete nothing produce no beat.
// Throughput: one byte per cycle while the receiver keeps taking results;
// the parse state machine makes one step per accepted byte. A byte that
// completes a result passes through a queue slot, then the result
// register, before the result is valid.
// A two-entry queue sits between the byte classifier and the parser, and the
// result register frees as it is taken, so the input keeps flowing while a
// result waits. When the receiver stalls, the parser halts and the queue
// fills; in_ready drops once it holds two bytes.
// Reset (rst_n low, synchronous) empties the queue and the result register
// and returns the parser to expecting a delta time with zero running status.
`timescale 1ns / 1ps

module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [31:0] out_delta_time,
  output logic [7:0]  out_status,
  output logic [7:0]  out_first_data,
  output logic [7:0]  out_second_data,
  output logic [31:0] out_meta_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload,
  output logic        out_end_of_track
);

  logic       q_valid;
  mtep_beat_t q_beat;
  logic       q_pop;

  mtep_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .q_valid      (q_valid),
    .q_beat       (q_beat),
    .q_pop        (q_pop)
  );

  mtep_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_beat           (q_beat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_delta_time   (out_delta_time),
    .out_status       (out_status),
    .out_first_data   (out_first_data),
    .out_second_data  (out_second_data),
    .out_meta_length  (out_meta_length),
    .out_payload_byte (out_payload_byte),
    .out_last_payload (out_last_payload),
    .out_end_of_track (out_end_of_track)
  );

`ifndef NO_ASSERTIONS
  a_meta_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_EVENT) |-> out_status == META_STATUS)
    else $error("meta beat without FF status");

  a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_payload |-> out_kind == KIND_PAYLOAD)
    else $error("last_payload on a non-payload beat");

  a_event_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EVENT) |-> out_meta_length == 32'd0 &&
      !out_end_of_track)
    else $error("channel event carries meta fields");

  a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !q_pop)
    else $error("parser advanced while result register is held");
`endif

endmodule
